/* hw/rtl/gws_pkg.sv */
// Shared constants and codes for the grid wave stencil update unit.
package gws_pkg;

  localparam int DEF_GRID_COLS = 128;
  localparam int DEF_GRID_ROWS = 128;
  localparam int DEF_VALUE_BITS = 24;
  localparam int FRAC_BITS = 16;

  localparam logic [1:0] FUNC_STEP = 2'd0;
  localparam logic [1:0] FUNC_DROP = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;
  localparam logic [7:0] CFG_RESET = 8'd128;

  localparam int RR_BITS = 12;
  localparam int D2_BITS = 13;
  localparam int QUOT_BITS = FRAC_BITS + 1;

endpackage

/* hw/rtl/gws_ram.sv */
// Single-port-write, single-port-read memory with registered read data.
module gws_ram #(
  parameter int AW = 14,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/gws_div.sv */
// Restoring divider producing (rr - d2) / rr with sixteen fraction bits.
module gws_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [gws_pkg::RR_BITS-1:0]    rr,
  input  logic [gws_pkg::D2_BITS-1:0]    d2,
  output logic                           done,
  output logic [gws_pkg::QUOT_BITS-1:0]  quot
);

  logic                          busy;
  logic [3:0]                    cnt;
  logic [gws_pkg::D2_BITS-1:0]   rem;
  logic [gws_pkg::D2_BITS:0]     trial;

  assign trial = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        quot <= {{(gws_pkg::QUOT_BITS-1){1'b0}}, (d2 == '0)};
        rem <= (d2 == '0) ? '0 : gws_pkg::D2_BITS'(rr) - d2;
      end else if (busy) begin
        if (trial >= (gws_pkg::D2_BITS+1)'(rr)) begin
          rem <= gws_pkg::D2_BITS'(trial - (gws_pkg::D2_BITS+1)'(rr));
          quot <= {quot[gws_pkg::QUOT_BITS-2:0], 1'b1};
        end else begin
          rem <= trial[gws_pkg::D2_BITS-1:0];
          quot <= {quot[gws_pkg::QUOT_BITS-2:0], 1'b0};
        end
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/grid_wave_stencil_update_unit.sv */
// Top level: sequencer over the height and speed memories with a shared adder and divider.
// Step: a speed pass over every interior cell, then a height pass, paced by the single
// height read port.
// Drop: visits every cell of the bounding square and runs the divider for each cell inside both circle and grid.
// Read: passes through two read states; other codes go straight to the result; one request at a time.
// After reset a clearing pass zeroes all 2^(row bits + column bits) words of both memories.
module grid_wave_stencil_update_unit #(
  parameter int GRID_COLS = gws_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = gws_pkg::DEF_GRID_ROWS,
  parameter int VALUE_BITS = gws_pkg::DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [6:0]         pos_x,
  input  logic [6:0]         pos_y,
  input  logic [5:0]         radius,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] cell_height,
  output logic [1:0]         status
);

  localparam int CW = $clog2(GRID_COLS);
  localparam int RW = $clog2(GRID_ROWS);
  localparam int AW = CW + RW;
  localparam int VB = VALUE_BITS;
  localparam int WW = (VB + 3 > 26) ? VB + 3 : 26;
  localparam int CLAMP_C = (GRID_COLS > 255) ? 255 : GRID_COLS;
  localparam int CLAMP_R = (GRID_ROWS > 255) ? 255 : GRID_ROWS;
  localparam logic signed [WW-1:0] V_HI = WW'((64'sd1 <<< (VB - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] V_LO = -V_HI - WW'(1);
  localparam logic signed [WW-1:0] O_HI = WW'(8388607);
  localparam logic signed [WW-1:0] O_LO = -O_HI - WW'(1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_P1 = 4'd2;
  localparam logic [3:0] S_P2 = 4'd3;
  localparam logic [3:0] S_DCHK = 4'd4;
  localparam logic [3:0] S_DDIV = 4'd5;
  localparam logic [3:0] S_RD1 = 4'd6;
  localparam logic [3:0] S_RD2 = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state;
  logic [7:0] width_in_use, height_in_use;
  logic [7:0] w, h;
  logic [AW-1:0] clr;
  logic [7:0] x, y;
  logic [2:0] ph;
  logic signed [WW-1:0] sum;
  logic sat;
  logic inside_r;
  logic [6:0] cx, cy;
  logic [5:0] r;
  logic signed [7:0] dx, dy;
  logic [gws_pkg::RR_BITS-1:0] rr;
  logic signed [23:0] res_value;
  logic [1:0] res_status;

  logic [AW-1:0] h_raddr, h_waddr, s_raddr, s_waddr;
  logic h_we, s_we;
  logic [VB-1:0] h_wdata, s_wdata, hq, sq;

  logic signed [WW-1:0] hq_e, sq_e, delta, nsp, nsp_s, nh, nh_s, q_e, q_s, rd_s;
  logic nsp_f, nh_f, q_f;
  logic signed [9:0] xs, ys;
  logic signed [15:0] dxx, dyy;
  logic [15:0] d2;
  logic pt_ok, in_grid, accept, last_cell, drop_last;
  logic div_start, div_done;
  logic [gws_pkg::QUOT_BITS-1:0] quot;

  function automatic logic [AW-1:0] addr_of(input logic [7:0] ax, input logic [7:0] ay);
    return {RW'(ay), CW'(ax)};
  endfunction

  assign w = (width_in_use > 8'(CLAMP_C)) ? 8'(CLAMP_C) : width_in_use;
  assign h = (height_in_use > 8'(CLAMP_R)) ? 8'(CLAMP_R) : height_in_use;
  assign in_grid = ({1'b0, pos_x} < w) && ({1'b0, pos_y} < h);
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use <= gws_pkg::CFG_RESET;
      height_in_use <= gws_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gws_pkg::CFG_WIDTH: width_in_use <= cfg_data;
        gws_pkg::CFG_HEIGHT: height_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  gws_ram #(.AW(AW), .DW(VB)) u_heights (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(hq)
  );

  gws_ram #(.AW(AW), .DW(VB)) u_speeds (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(sq)
  );

  gws_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .rr(rr),
    .d2(gws_pkg::D2_BITS'(d2)), .done(div_done), .quot(quot)
  );

  assign hq_e = WW'($signed(hq));
  assign sq_e = WW'($signed(sq));
  assign delta = (sum >>> 2) - hq_e;
  assign nsp = sq_e + delta;
  assign nh = hq_e + sq_e;
  assign q_e = WW'(quot);

  assign nsp_f = (nsp > V_HI) || (nsp < V_LO);
  assign nsp_s = (nsp > V_HI) ? V_HI : ((nsp < V_LO) ? V_LO : nsp);
  assign nh_f = (nh > V_HI) || (nh < V_LO);
  assign nh_s = (nh > V_HI) ? V_HI : ((nh < V_LO) ? V_LO : nh);
  assign q_f = (q_e > V_HI);
  assign q_s = q_f ? V_HI : q_e;
  assign rd_s = (hq_e > O_HI) ? O_HI : ((hq_e < O_LO) ? O_LO : hq_e);

  assign xs = $signed({3'b000, cx}) + 10'(dx);
  assign ys = $signed({3'b000, cy}) + 10'(dy);
  assign dxx = dx * dx;
  assign dyy = dy * dy;
  assign d2 = 16'(dxx) + 16'(dyy);
  assign pt_ok = !xs[9] && !ys[9] && (xs[8:0] < {1'b0, w}) && (ys[8:0] < {1'b0, h})
              && (d2 <= 16'(rr));
  assign div_start = (state == S_DCHK) && pt_ok;
  assign last_cell = (x == w - 8'd2) && (y == h - 8'd2);
  assign drop_last = (dx == $signed(8'(r))) && (dy == $signed(8'(r)));

  always_comb begin
    unique case (state)
      S_P1: begin
        unique case (ph)
          3'd0: h_raddr = addr_of(x - 8'd1, y);
          3'd1: h_raddr = addr_of(x + 8'd1, y);
          3'd2: h_raddr = addr_of(x, y - 8'd1);
          3'd3: h_raddr = addr_of(x, y + 8'd1);
          default: h_raddr = addr_of(x, y);
        endcase
      end
      S_RD1: h_raddr = addr_of({1'b0, cx}, {1'b0, cy});
      default: h_raddr = addr_of(x, y);
    endcase
    s_raddr = addr_of(x, y);

    h_we = 1'b0;
    h_waddr = addr_of(x, y);
    h_wdata = VB'(nh_s);
    s_we = 1'b0;
    s_waddr = addr_of(x, y);
    s_wdata = VB'(nsp_s);
    unique case (state)
      S_CLEAR: begin
        h_we = 1'b1;
        s_we = 1'b1;
        h_waddr = clr;
        s_waddr = clr;
        h_wdata = '0;
        s_wdata = '0;
      end
      S_P1: s_we = (ph == 3'd5);
      S_P2: h_we = (ph == 3'd1);
      S_DDIV: begin
        h_we = div_done;
        h_waddr = addr_of(xs[7:0], ys[7:0]);
        h_wdata = VB'(q_s);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_value <= '0;
            sat <= 1'b0;
            x <= 8'd1;
            y <= 8'd1;
            ph <= '0;
            sum <= '0;
            cx <= pos_x;
            cy <= pos_y;
            r <= radius;
            inside_r <= in_grid;
            rr <= gws_pkg::RR_BITS'(radius) * gws_pkg::RR_BITS'(radius);
            dx <= -$signed(8'(radius));
            dy <= -$signed(8'(radius));
            unique case (func)
              gws_pkg::FUNC_STEP: begin
                res_status <= gws_pkg::ST_DONE;
                state <= (w < 8'd3 || h < 8'd3) ? S_DONE : S_P1;
              end
              gws_pkg::FUNC_DROP: begin
                res_status <= in_grid ? gws_pkg::ST_DONE : gws_pkg::ST_OUTSIDE;
                state <= (radius == '0) ? S_DONE : S_DCHK;
              end
              gws_pkg::FUNC_READ: begin
                res_status <= in_grid ? gws_pkg::ST_DONE : gws_pkg::ST_OUTSIDE;
                state <= in_grid ? S_RD1 : S_DONE;
              end
              default: begin
                res_status <= gws_pkg::ST_DONE;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_P1: begin
          if (ph == 3'd5) begin
            ph <= '0;
            sum <= '0;
            if (nsp_f) begin
              sat <= 1'b1;
            end
            if (last_cell) begin
              x <= 8'd1;
              y <= 8'd1;
              state <= S_P2;
            end else if (x == w - 8'd2) begin
              x <= 8'd1;
              y <= y + 8'd1;
            end else begin
              x <= x + 8'd1;
            end
          end else begin
            ph <= ph + 3'd1;
            if (ph >= 3'd1 && ph <= 3'd4) begin
              sum <= sum + hq_e;
            end
          end
        end
        S_P2: begin
          if (ph == 3'd1) begin
            ph <= '0;
            if (x == w - 8'd2) begin
              x <= 8'd1;
              y <= y + 8'd1;
            end else begin
              x <= x + 8'd1;
            end
            if (last_cell) begin
              state <= S_DONE;
              res_status <= (sat || nh_f) ? gws_pkg::ST_SAT : gws_pkg::ST_DONE;
            end
            if (nh_f) begin
              sat <= 1'b1;
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        S_DCHK, S_DDIV: begin
          if ((state == S_DCHK && !pt_ok) || (state == S_DDIV && div_done)) begin
            if (state == S_DDIV && q_f) begin
              sat <= 1'b1;
            end
            state <= drop_last ? S_DONE : S_DCHK;
            if (dx == $signed(8'(r))) begin
              dx <= -$signed(8'(r));
              dy <= dy + 8'sd1;
            end else begin
              dx <= dx + 8'sd1;
            end
            if (drop_last) begin
              res_status <= !inside_r ? gws_pkg::ST_OUTSIDE
                          : ((sat || (state == S_DDIV && q_f)) ? gws_pkg::ST_SAT
                                                                : gws_pkg::ST_DONE);
            end
          end else if (state == S_DCHK) begin
            state <= S_DDIV;
          end
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          res_value <= 24'(rd_s);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            cell_height <= res_value;
            status <= res_status;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* dv/gws_checker.sv */
// Checker for the grid wave stencil update unit: grid prediction and result comparison.
module gws_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         func,
  input  logic [6:0]         pos_x,
  input  logic [6:0]         pos_y,
  input  logic [5:0]         radius,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [23:0] cell_height,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = gws_pkg::DEF_GRID_COLS;
  localparam int ROWS = gws_pkg::DEF_GRID_ROWS;
  localparam int VAL_MAX = (1 << (gws_pkg::DEF_VALUE_BITS - 1)) - 1;
  localparam int VAL_MIN = -VAL_MAX - 1;

  typedef struct packed {
    logic signed [23:0] height;
    logic [1:0]         st;
  } cell_result_t;

  int heights [COLS*ROWS];
  int speeds [COLS*ROWS];
  logic [7:0] width_reg;
  logic [7:0] height_reg;
  cell_result_t expected_results [$];
  int errors;

  function automatic int saturate(int v, inout bit sat);
    if (v > VAL_MAX) begin
      sat = 1'b1;
      return VAL_MAX;
    end
    if (v < VAL_MIN) begin
      sat = 1'b1;
      return VAL_MIN;
    end
    return v;
  endfunction

  function automatic cell_result_t predict_request(logic [1:0] f, int px, int py, int r);
    cell_result_t res;
    int w, h, sum, idx, rr, d2;
    bit sat;
    bit in_grid;
    w = (width_reg > COLS) ? COLS : int'(width_reg);
    h = (height_reg > ROWS) ? ROWS : int'(height_reg);
    in_grid = (px < w) && (py < h);
    sat = 1'b0;
    res.height = '0;
    res.st = gws_pkg::ST_DONE;
    case (f)
      gws_pkg::FUNC_STEP: begin
        for (int y = 1; y < h - 1; y++)
          for (int x = 1; x < w - 1; x++) begin
            idx = y * COLS + x;
            sum = heights[idx-1] + heights[idx+1] + heights[idx-COLS] + heights[idx+COLS];
            speeds[idx] = saturate(speeds[idx] + (sum >>> 2) - heights[idx], sat);
          end
        for (int y = 1; y < h - 1; y++)
          for (int x = 1; x < w - 1; x++) begin
            idx = y * COLS + x;
            heights[idx] = saturate(heights[idx] + speeds[idx], sat);
          end
        if (sat) res.st = gws_pkg::ST_SAT;
      end
      gws_pkg::FUNC_DROP: begin
        rr = r * r;
        if (r != 0)
          for (int y = py - r; y <= py + r; y++)
            for (int x = px - r; x <= px + r; x++) begin
              d2 = (x - px) * (x - px) + (y - py) * (y - py);
              if (x >= 0 && y >= 0 && x < w && y < h && d2 <= rr)
                heights[y*COLS+x] = saturate(((rr - d2) << gws_pkg::FRAC_BITS) / rr, sat);
            end
        if (!in_grid) res.st = gws_pkg::ST_OUTSIDE;
        else if (sat) res.st = gws_pkg::ST_SAT;
      end
      gws_pkg::FUNC_READ: begin
        if (in_grid) res.height = heights[py*COLS+px];
        else res.st = gws_pkg::ST_OUTSIDE;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    cell_result_t want;
    if (rst) begin
      for (int i = 0; i < COLS * ROWS; i++) begin
        heights[i] = 0;
        speeds[i] = 0;
      end
      width_reg = gws_pkg::CFG_RESET;
      height_reg = gws_pkg::CFG_RESET;
      expected_results.delete();
      errors = 0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gws_pkg::CFG_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (errors < 10)
            $display("%0t: result with nothing expected: height %0d status %0d",
                     $realtime, cell_height, status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (want.height !== cell_height || want.st !== status) begin
            if (errors < 10)
              $display("%0t: mismatch: expected height %0d status %0d, got %0d status %0d",
                       $realtime, want.height, want.st, cell_height, status);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_request(func, pos_x, pos_y, radius));
      fail_count <= errors;
      pending <= expected_results.size();
    end
  end

endmodule

/* dv/tb_grid_wave_stencil_update_unit.sv */
// Testbench top for the grid wave stencil update unit: stimulus, idling and verdict.
module tb_grid_wave_stencil_update_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = gws_pkg::CFG_WIDTH;
  logic [7:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = gws_pkg::FUNC_STEP;
  logic [6:0]         pos_x = '0;
  logic [6:0]         pos_y = '0;
  logic [5:0]         radius = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [23:0] cell_height;
  logic [1:0]         status;
  int                 fail_count;
  int                 pending;

  bit idle_on = 1'b1;
  bit long_hold = 1'b0;
  int cols_now = 128;
  int rows_now = 128;
  int func_counts [4];
  int cfg_writes = 0;

  always #5 clk = ~clk;

  grid_wave_stencil_update_unit u_dut (.*);

  gws_checker u_checker (.*);

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send(logic [1:0] f, int x, int y, int r);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    pos_x <= x[6:0];
    pos_y <= y[6:0];
    radius <= r[5:0];
    func_counts[f]++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_grid(logic [7:0] w, logic [7:0] h);
    wait_idle();
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= gws_pkg::CFG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= gws_pkg::CFG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cols_now = (w > 128) ? 128 : int'(w);
    rows_now = (h > 128) ? 128 : int'(h);
    cfg_writes += 2;
  endtask

  task automatic send_random();
    int pick, x, y, r;
    logic [1:0] f;
    pick = $urandom_range(0, 19);
    f = (pick < 6) ? gws_pkg::FUNC_STEP : (pick < 12) ? gws_pkg::FUNC_DROP :
        (pick < 19) ? gws_pkg::FUNC_READ : FUNC_UNUSED;
    if ($urandom_range(0, 3) != 0 && cols_now > 0 && rows_now > 0) begin
      x = $urandom_range(0, cols_now - 1);
      y = $urandom_range(0, rows_now - 1);
    end else begin
      x = $urandom_range(0, 127);
      y = $urandom_range(0, 127);
    end
    r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
    send(f, x, y, r);
  endtask

  always begin
    int n;
    n = idle_on ? $urandom_range(0, 6) : 0;
    if (long_hold) begin
      n = 400;
      long_hold = 1'b0;
    end
    if (n > 0) begin
      out_stall <= 1'b1;
      repeat (n) @(posedge clk);
    end
    out_stall <= 1'b0;
    do @(posedge clk); while (!out_valid);
  end

  initial begin
    #200_000_000;
    $display("grid_wave_stencil_update_unit test failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full grid after reset: empty read, drops, one full step, the largest radius.
    send(gws_pkg::FUNC_READ, 0, 0, 0);
    send(gws_pkg::FUNC_DROP, 64, 64, 5);
    send(gws_pkg::FUNC_READ, 64, 64, 0);
    send(gws_pkg::FUNC_READ, 66, 64, 0);
    send(gws_pkg::FUNC_STEP, 0, 0, 0);
    send(gws_pkg::FUNC_READ, 64, 64, 0);
    send(gws_pkg::FUNC_READ, 65, 63, 0);
    send(gws_pkg::FUNC_DROP, 10, 10, 0);
    send(gws_pkg::FUNC_DROP, 127, 127, 63);
    send(gws_pkg::FUNC_READ, 127, 127, 0);
    send(FUNC_UNUSED, 127, 127, 63);

    // Oversized width with a thin grid, then a grid with no interior, then a narrow tall grid.
    set_grid(8'd255, 8'd3);
    send(gws_pkg::FUNC_STEP, 0, 0, 0);
    send(gws_pkg::FUNC_DROP, 0, 0, 1);
    send(gws_pkg::FUNC_READ, 127, 2, 0);
    send(gws_pkg::FUNC_READ, 5, 3, 0);
    send(gws_pkg::FUNC_DROP, 127, 127, 2);
    set_grid(8'd0, 8'd1);
    send(gws_pkg::FUNC_STEP, 0, 0, 0);
    send(gws_pkg::FUNC_READ, 0, 0, 0);
    send(gws_pkg::FUNC_DROP, 0, 0, 3);
    set_grid(8'd3, 8'd128);
    send(gws_pkg::FUNC_STEP, 0, 0, 0);
    send(gws_pkg::FUNC_READ, 1, 64, 0);
    send(gws_pkg::FUNC_READ, 2, 127, 0);

    // The receiver holds off for a long stretch while requests keep coming.
    set_grid(8'd12, 8'd12);
    long_hold = 1'b1;
    idle_on = 1'b0;
    send(gws_pkg::FUNC_DROP, 6, 6, 4);
    repeat (4) send(gws_pkg::FUNC_READ, 6, 6, 0);
    idle_on = 1'b1;
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      set_grid(8'($urandom_range(3, 20)), 8'($urandom_range(3, 20)));
      idle_on = (phase != 2);
      send(gws_pkg::FUNC_DROP, cols_now / 2, rows_now / 2, $urandom_range(1, 6));
      for (int i = 0; i < 19; i++) send_random();
    end
    idle_on = 1'b1;
    in_valid <= 1'b0;

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Covered %0d steps, %0d drops, %0d reads and %0d unused codes,",
             func_counts[gws_pkg::FUNC_STEP], func_counts[gws_pkg::FUNC_DROP],
             func_counts[gws_pkg::FUNC_READ], func_counts[FUNC_UNUSED]);
    $display("across %0d register writes, with and without idling on both sides.", cfg_writes);
    if (fail_count == 0) begin
      $display("grid_wave_stencil_update_unit test passed");
    end else begin
      $display("grid_wave_stencil_update_unit test failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/gws_pkg.sv
hw/rtl/gws_ram.sv
hw/rtl/gws_div.sv
hw/rtl/grid_wave_stencil_update_unit.sv
dv/gws_checker.sv
dv/tb_grid_wave_stencil_update_unit.sv
